### hw/rtl/rhc_pkg.sv
// ============================================================================
// rhc_pkg
// Shared types and constants of the RGB to HSV colour converter.
// ============================================================================
`default_nettype none

package rhc_pkg;

  localparam int CHANNEL_BITS      = 8;
  localparam int HUE_FRACTION_BITS = 6;
  localparam int HUE_BITS          = 15;
  localparam int SAT_BITS          = 16;

  // Divider shape: the quotient never needs more than SAT_BITS bits.
  localparam int DIV_DEN_BITS = CHANNEL_BITS;
  localparam int DIV_QUO_BITS = SAT_BITS;
  localparam int DIV_NUM_BITS = DIV_DEN_BITS + DIV_QUO_BITS;

  localparam int SAT_FULL  = (1 << SAT_BITS) - 1;
  localparam int HUE_SIXTY = 60 << HUE_FRACTION_BITS;

  localparam logic [HUE_BITS-1:0] HUE_GREEN = HUE_BITS'(2 * HUE_SIXTY);
  localparam logic [HUE_BITS-1:0] HUE_BLUE  = HUE_BITS'(4 * HUE_SIXTY);
  localparam logic [HUE_BITS-1:0] HUE_FULL  = HUE_BITS'(360 << HUE_FRACTION_BITS);

  // Cycles from the accepting edge to the edge that takes the result.
  localparam int RHC_LATENCY = DIV_QUO_BITS + 3;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } rhc_in_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]     hue;
    logic [SAT_BITS-1:0]     saturation;
    logic [CHANNEL_BITS-1:0] brightness;
    logic                    achromatic;
  } rhc_out_t;

  // One classified pixel, queued between front and back.
  typedef struct packed {
    logic [DIV_NUM_BITS-1:0] sat_num;
    logic [DIV_DEN_BITS-1:0] sat_den;
    logic [DIV_NUM_BITS-1:0] hue_num;
    logic [DIV_DEN_BITS-1:0] hue_den;
    sector_t                 sector;
    logic                    neg;
    logic                    achro;
    logic [CHANNEL_BITS-1:0] bright;
  } rhc_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

`default_nettype wire

### hw/rtl/rgb_to_hsv_converter_top.sv
// ============================================================================
// rgb_to_hsv_converter_top
// RGB to HSV colour converter: classifying front, queue, divider back end.
// ============================================================================
// Throughput: one pixel per clock; busy stays low in use, as the back end
// drains the queue every cycle and the result side cannot stall.
// Path: an accepted pixel passes the front register, a queue entry, the
// 16-stage quotient pipeline and the output register before its strobe.
// Reset: synchronous, active low; clears the queue and all valid bits.
`default_nettype none

module rgb_to_hsv_converter_top (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire rhc_pkg::rhc_in_t in_data,
  output logic                  out_strobe,
  output rhc_pkg::rhc_out_t     out_data
);
  import rhc_pkg::*;

  logic         front_vld;
  rhc_job_t     front_job, queue_job;
  fifo_status_t queue_status;

  rhc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (start),
    .in_data_i   (in_data),
    .fifo_full_i (queue_status.full),
    .busy_o      (busy),
    .job_vld_o   (front_vld),
    .job_o       (front_job)
  );

  rhc_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (front_vld),
    .push_data_i (front_job),
    .pop_i       (1'b1),
    .pop_data_o  (queue_job),
    .status_o    (queue_status)
  );

  rhc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_vld_i    (~queue_status.empty),
    .job_i        (queue_job),
    .out_strobe_o (out_strobe),
    .out_data_o   (out_data)
  );

endmodule

`default_nettype wire

### hw/rtl/rhc_front.sv
// ============================================================================
// rhc_front
// Accepts a pixel, finds max, min and hue sector, and forms both dividends.
// ============================================================================
`default_nettype none

module rhc_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start_i,
  input  wire rhc_pkg::rhc_in_t  in_data_i,
  input  wire logic              fifo_full_i,
  output logic                   busy_o,
  output logic                   job_vld_o,
  output rhc_pkg::rhc_job_t      job_o
);
  import rhc_pkg::*;

  logic                    accept;
  logic                    job_vld_r, job_vld_nxt;
  rhc_job_t                job_r, job_nxt;
  logic [CHANNEL_BITS-1:0] r, g, b, mx_rg, mn_rg, mx, mn, delta, minu, subt, mag;
  logic                    neg;
  sector_t                 sector;

  assign busy_o    = job_vld_r & fifo_full_i;
  assign accept    = start_i & ~busy_o;
  assign job_vld_o = job_vld_r;
  assign job_o     = job_r;

  always_comb begin
    r      = in_data_i.red;
    g      = in_data_i.green;
    b      = in_data_i.blue;
    mx_rg  = (r > g) ? r : g;
    mn_rg  = (r < g) ? r : g;
    mx     = (b > mx_rg) ? b : mx_rg;
    mn     = (b < mn_rg) ? b : mn_rg;
    delta  = mx - mn;
    // Ties go to red first, then green.
    if (r == mx) begin
      sector = SECT_RED;
      minu   = g;
      subt   = b;
    end else if (g == mx) begin
      sector = SECT_GREEN;
      minu   = b;
      subt   = r;
    end else begin
      sector = SECT_BLUE;
      minu   = r;
      subt   = g;
    end
    neg = subt > minu;
    mag = neg ? (subt - minu) : (minu - subt);

    job_nxt         = job_r;
    job_nxt.sat_num = DIV_NUM_BITS'(delta) * DIV_NUM_BITS'(SAT_FULL);
    job_nxt.sat_den = mx;
    job_nxt.hue_num = DIV_NUM_BITS'(mag) * DIV_NUM_BITS'(HUE_SIXTY);
    job_nxt.hue_den = delta;
    job_nxt.sector  = sector;
    job_nxt.neg     = neg;
    job_nxt.achro   = (delta == '0);
    job_nxt.bright  = mx;
  end

  assign job_vld_nxt = accept | busy_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
    end else begin
      job_vld_r <= job_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rhc_fifo.sv
// ============================================================================
// rhc_fifo
// Two-entry queue of classified pixels between front and back.
// ============================================================================
`default_nettype none

module rhc_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_i,
  input  wire rhc_pkg::rhc_job_t push_data_i,
  input  wire logic              pop_i,
  output rhc_pkg::rhc_job_t      pop_data_o,
  output rhc_pkg::fifo_status_t  status_o
);
  import rhc_pkg::*;

  rhc_job_t   entry_r [0:1];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign status_o.full  = (count_r == 2'd2);
  assign status_o.empty = (count_r == 2'd0);
  assign do_push        = push_i & ~status_o.full;
  assign do_pop         = pop_i & ~status_o.empty;
  assign pop_data_o     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rhc_div.sv
// ============================================================================
// rhc_div
// Pipelined restoring divider, one quotient bit per stage.
// ============================================================================
`default_nettype none

module rhc_div #(
  parameter int DEN_BITS = rhc_pkg::DIV_DEN_BITS,
  parameter int QUO_BITS = rhc_pkg::DIV_QUO_BITS
) (
  input  wire logic                         clk,
  input  wire logic [DEN_BITS+QUO_BITS-1:0] num_i,
  input  wire logic [DEN_BITS-1:0]          den_i,
  output logic [QUO_BITS-1:0]               quo_o
);
  localparam int NUM_BITS = DEN_BITS + QUO_BITS;

  // The dividend is known to be below den * 2**QUO_BITS, so its top
  // DEN_BITS bits start out as a remainder smaller than the divisor.
  logic [DEN_BITS-1:0] rem_r [1:QUO_BITS-1];
  logic [DEN_BITS-1:0] den_r [1:QUO_BITS-1];
  logic [QUO_BITS-1:0] low_r [1:QUO_BITS-1];
  logic [QUO_BITS-1:0] quo_r [1:QUO_BITS];

  assign quo_o = quo_r[QUO_BITS];

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
    logic [DEN_BITS-1:0] rem_in, den_in;
    logic [QUO_BITS-1:0] low_in, quo_in;
    logic [DEN_BITS:0]   trial;
    logic                take;

    if (k == 0) begin : g_first
      assign rem_in = num_i[NUM_BITS-1:QUO_BITS];
      assign low_in = num_i[QUO_BITS-1:0];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k];
      assign low_in = low_r[k];
      assign den_in = den_r[k];
      assign quo_in = quo_r[k];
    end

    assign trial = {rem_in, low_in[QUO_BITS-1]};
    assign take  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      quo_r[k+1] <= {quo_in[QUO_BITS-2:0], take};
    end

    if (k < QUO_BITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[k+1] <= take ? DEN_BITS'(trial - {1'b0, den_in}) : trial[DEN_BITS-1:0];
        low_r[k+1] <= {low_in[QUO_BITS-2:0], 1'b0};
        den_r[k+1] <= den_in;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rhc_back.sv
// ============================================================================
// rhc_back
// Runs both divisions, carries the pixel alongside and assembles the result.
// ============================================================================
`default_nettype none

module rhc_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_vld_i,
  input  wire rhc_pkg::rhc_job_t job_i,
  output logic                   out_strobe_o,
  output rhc_pkg::rhc_out_t      out_data_o
);
  import rhc_pkg::*;

  typedef struct packed {
    sector_t                 sector;
    logic                    neg;
    logic                    achro;
    logic [CHANNEL_BITS-1:0] bright;
  } side_t;

  logic [DIV_QUO_BITS-1:0] sat_q, hue_q;
  side_t                   side_r [1:DIV_QUO_BITS];
  logic [DIV_QUO_BITS:1]   vld_r;
  logic [HUE_BITS-1:0]     frac, base, hue;
  side_t                   tail;
  logic                    out_strobe_r;
  rhc_out_t                out_data_r, out_data_nxt;

  rhc_div #(.DEN_BITS(DIV_DEN_BITS), .QUO_BITS(DIV_QUO_BITS)) u_sat_div (
    .clk   (clk),
    .num_i (job_i.sat_num),
    .den_i (job_i.sat_den),
    .quo_o (sat_q)
  );

  rhc_div #(.DEN_BITS(DIV_DEN_BITS), .QUO_BITS(DIV_QUO_BITS)) u_hue_div (
    .clk   (clk),
    .num_i (job_i.hue_num),
    .den_i (job_i.hue_den),
    .quo_o (hue_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DIV_QUO_BITS-1:1], job_vld_i};
    end
  end

  always_ff @(posedge clk) begin
    side_r[1] <= '{sector: job_i.sector, neg: job_i.neg, achro: job_i.achro,
                   bright: job_i.bright};
    for (int i = 2; i <= DIV_QUO_BITS; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  always_comb begin
    tail = side_r[DIV_QUO_BITS];
    frac = hue_q[HUE_BITS-1:0];
    case (tail.sector)
      SECT_RED:   base = '0;
      SECT_GREEN: base = HUE_GREEN;
      SECT_BLUE:  base = HUE_BLUE;
      default:    base = '0;
    endcase
    // Only the red sector can go below zero, and then wraps by a full turn.
    if (!tail.neg) begin
      hue = base + frac;
    end else if (tail.sector == SECT_RED) begin
      hue = HUE_FULL - frac;
    end else begin
      hue = base - frac;
    end
    out_data_nxt.hue        = tail.achro ? '0 : hue;
    out_data_nxt.saturation = tail.achro ? '0 : sat_q;
    out_data_nxt.brightness = tail.bright;
    out_data_nxt.achromatic = tail.achro;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= vld_r[DIV_QUO_BITS];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_strobe_o = out_strobe_r;
  assign out_data_o   = out_data_r;

endmodule

`default_nettype wire

### hw/rtl/rhc_checker.sv
// ============================================================================
// rhc_checker
// Port-level checks of the RGB to HSV colour converter.
// ============================================================================
`default_nettype none

module rhc_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             out_strobe,
  input wire rhc_pkg::rhc_out_t out_data
);
  import rhc_pkg::*;

  // Every accepted transaction yields its result a fixed time later.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(RHC_LATENCY) out_strobe)
    else $error("result missing after accepted transaction");

  // Saturation is zero exactly for grey pixels.
  a_achro_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.achromatic == (out_data.saturation == '0)))
    else $error("achromatic flag disagrees with saturation");

  a_achro_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.achromatic) |-> (out_data.hue == '0))
    else $error("grey pixel with non-zero hue");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.hue < HUE_FULL))
    else $error("hue beyond a full turn");

  a_bright: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.achromatic) |-> (out_data.brightness != '0))
    else $error("coloured pixel with zero brightness");

endmodule

bind rgb_to_hsv_converter_top rhc_checker u_rhc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);

`default_nettype wire
